// ----- rtl/stor_pkg.sv -----
// Shared constants, command and status types of the sample table offset resolver.
package stor_pkg;

    localparam int RUN_DEPTH    = 64;
    localparam int CHUNK_DEPTH  = 1024;
    localparam int SAMPLE_DEPTH = 4096;

    localparam int RUN_AW    = $clog2(RUN_DEPTH + 1);
    localparam int CHUNK_AW  = $clog2(CHUNK_DEPTH + 1);
    localparam int SAMPLE_AW = $clog2(SAMPLE_DEPTH + 1);

    localparam int OP_W       = 3;
    localparam int IDX_W      = 13;
    localparam int FIRST_W    = 11;
    localparam int SPC_W      = 16;
    localparam int DESC_W     = 16;
    localparam int OFF_W      = 64;
    localparam int SIZE_W     = 32;
    localparam int NUM_W      = 13;
    localparam int STS_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int RUNS_W     = 7;
    localparam int SAMPLES_W  = 13;
    localparam int CHUNKS_W   = 11;
    localparam int COUNT_W    = 34;
    localparam int PROD_W     = 48;
    localparam int DIVCNT_W   = $clog2(NUM_W);

    localparam logic [OP_W-1:0] OP_LOAD_RUN     = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_CHUNK   = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_SAMPLE  = 3'd2;
    localparam logic [OP_W-1:0] OP_SAMPLE_QUERY = 3'd3;
    localparam logic [OP_W-1:0] OP_CHUNK_QUERY  = 3'd4;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
    localparam logic [STS_W-1:0] STS_ZERO  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT  = 2'd3;

    localparam logic [PROD_W-1:0] SIZE_SAT = PROD_W'(64'hFFFF_FFFF);

    typedef enum logic [4:0] {
        DP_IDLE        = 5'd0,
        DP_LATCH       = 5'd1,
        DP_START       = 5'd2,
        DP_CUR_TAKE    = 5'd3,
        DP_NXT_TAKE    = 5'd4,
        DP_ADVANCE     = 5'd5,
        DP_DIV_INIT    = 5'd6,
        DP_DIV_STEP    = 5'd7,
        DP_SQ_OFF      = 5'd8,
        DP_SQ_FIX_MUL  = 5'd9,
        DP_SQ_FIX_FIN  = 5'd10,
        DP_SQ_SUM_INIT = 5'd11,
        DP_SQ_ACC      = 5'd12,
        DP_SQ_FIN      = 5'd13,
        DP_CQ_MUL      = 5'd14,
        DP_CQ_ADD      = 5'd15,
        DP_CQ_FIX_MUL  = 5'd16,
        DP_CQ_SUM_INIT = 5'd17,
        DP_CQ_ACC      = 5'd18,
        DP_CQ_FIN      = 5'd19,
        DP_ERR_RANGE   = 5'd20,
        DP_ERR_ZERO    = 5'd21
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } stor_cmd_t;

    typedef struct packed {
        logic is_query;
        logic is_sample;
        logic range_bad;
        logic more_runs;
        logic chunk_break;
        logic step_hit;
        logic spc_zero;
        logic below_first;
        logic div_last;
        logic chunk_bad;
        logic fixed_on;
        logic sq_more;
        logic cq_more;
    } stor_flags_t;

    typedef struct packed {
        logic [FIRST_W-1:0] first;
        logic [SPC_W-1:0]   spc;
        logic [DESC_W-1:0]  desc;
    } run_entry_t;

endpackage

// ----- rtl/stor_ctrl.sv -----
// Sequencing state machine of the sample table offset resolver.
module stor_ctrl
    import stor_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        out_stall,
    input  stor_flags_t flags,
    output stor_cmd_t   cmd,
    output logic        in_stall,
    output logic        out_valid
);

    typedef enum logic [20:0] {
        ST_IDLE        = 21'h000001,
        ST_CHECK       = 21'h000002,
        ST_RUN_FIRST   = 21'h000004,
        ST_WALK_RD     = 21'h000008,
        ST_WALK_MUL    = 21'h000010,
        ST_WALK_STEP   = 21'h000020,
        ST_WALK_END    = 21'h000040,
        ST_DIV         = 21'h000080,
        ST_SQ_CHK      = 21'h000100,
        ST_SQ_FIXMUL   = 21'h000200,
        ST_SQ_FIXFIN   = 21'h000400,
        ST_SQ_SUMINIT  = 21'h000800,
        ST_SQ_LOOP_RD  = 21'h001000,
        ST_SQ_LOOP_ACC = 21'h002000,
        ST_SQ_LAST     = 21'h004000,
        ST_CQ_ADD      = 21'h008000,
        ST_CQ_SIZE     = 21'h010000,
        ST_CQ_LOOP_RD  = 21'h020000,
        ST_CQ_LOOP_ACC = 21'h040000,
        ST_CQ_FIN      = 21'h080000,
        ST_DONE        = 21'h100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = DP_IDLE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!flags.is_query)
                begin
                    state_next = ST_IDLE;
                end
                else if (flags.range_bad)
                begin
                    cmd.op     = DP_ERR_RANGE;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = DP_START;
                    state_next = ST_RUN_FIRST;
                end
            end
            ST_RUN_FIRST:
            begin
                cmd.op     = DP_CUR_TAKE;
                state_next = ST_WALK_RD;
            end
            ST_WALK_RD:
            begin
                state_next = flags.more_runs ? ST_WALK_MUL : ST_WALK_END;
            end
            ST_WALK_MUL:
            begin
                cmd.op = DP_NXT_TAKE;
                if (!flags.is_sample && flags.chunk_break)
                begin
                    state_next = ST_WALK_END;
                end
                else
                begin
                    state_next = ST_WALK_STEP;
                end
            end
            ST_WALK_STEP:
            begin
                if (flags.is_sample && flags.step_hit)
                begin
                    state_next = ST_WALK_END;
                end
                else
                begin
                    cmd.op     = DP_ADVANCE;
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_END:
            begin
                if (flags.is_sample)
                begin
                    if (flags.spc_zero)
                    begin
                        cmd.op     = DP_ERR_ZERO;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.op     = DP_DIV_INIT;
                        state_next = ST_DIV;
                    end
                end
                else if (flags.below_first)
                begin
                    cmd.op     = DP_ERR_RANGE;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = DP_CQ_MUL;
                    state_next = ST_CQ_ADD;
                end
            end
            ST_DIV:
            begin
                cmd.op = DP_DIV_STEP;
                if (flags.div_last)
                begin
                    state_next = ST_SQ_CHK;
                end
            end
            ST_SQ_CHK:
            begin
                if (flags.chunk_bad)
                begin
                    cmd.op     = DP_ERR_RANGE;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = DP_SQ_OFF;
                    state_next = flags.fixed_on ? ST_SQ_FIXMUL : ST_SQ_SUMINIT;
                end
            end
            ST_SQ_FIXMUL:
            begin
                cmd.op     = DP_SQ_FIX_MUL;
                state_next = ST_SQ_FIXFIN;
            end
            ST_SQ_FIXFIN:
            begin
                cmd.op     = DP_SQ_FIX_FIN;
                state_next = ST_DONE;
            end
            ST_SQ_SUMINIT:
            begin
                cmd.op     = DP_SQ_SUM_INIT;
                state_next = ST_SQ_LOOP_RD;
            end
            ST_SQ_LOOP_RD:
            begin
                state_next = flags.sq_more ? ST_SQ_LOOP_ACC : ST_SQ_LAST;
            end
            ST_SQ_LOOP_ACC:
            begin
                cmd.op     = DP_SQ_ACC;
                state_next = ST_SQ_LOOP_RD;
            end
            ST_SQ_LAST:
            begin
                cmd.op     = DP_SQ_FIN;
                state_next = ST_DONE;
            end
            ST_CQ_ADD:
            begin
                cmd.op     = DP_CQ_ADD;
                state_next = ST_CQ_SIZE;
            end
            ST_CQ_SIZE:
            begin
                if (flags.fixed_on)
                begin
                    cmd.op     = DP_CQ_FIX_MUL;
                    state_next = ST_CQ_FIN;
                end
                else
                begin
                    cmd.op     = DP_CQ_SUM_INIT;
                    state_next = ST_CQ_LOOP_RD;
                end
            end
            ST_CQ_LOOP_RD:
            begin
                state_next = flags.cq_more ? ST_CQ_LOOP_ACC : ST_CQ_FIN;
            end
            ST_CQ_LOOP_ACC:
            begin
                cmd.op     = DP_CQ_ACC;
                state_next = ST_CQ_LOOP_RD;
            end
            ST_CQ_FIN:
            begin
                cmd.op     = DP_CQ_FIN;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/stor_dpath.sv -----
// Table stores, configuration registers and arithmetic of the sample table offset resolver.
module stor_dpath
    import stor_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [OP_W-1:0]       operation,
    input  logic [IDX_W-1:0]      table_index,
    input  logic [FIRST_W-1:0]    run_first_chunk,
    input  logic [SPC_W-1:0]      run_samples_per_chunk,
    input  logic [DESC_W-1:0]     run_description_index,
    input  logic [OFF_W-1:0]      chunk_byte_offset,
    input  logic [SIZE_W-1:0]     sample_byte_size,
    input  logic [NUM_W-1:0]      query_number,
    input  stor_cmd_t             cmd,
    output stor_flags_t           flags,
    output logic [OFF_W-1:0]      byte_offset,
    output logic [SIZE_W-1:0]     byte_size,
    output logic [DESC_W-1:0]     description_index,
    output logic [STS_W-1:0]      status
);

    logic [SIZE_W-1:0]    fixed_reg;
    logic [RUNS_W-1:0]    runs_cfg_reg;
    logic [SAMPLES_W-1:0] samples_cfg_reg;
    logic [CHUNKS_W-1:0]  chunks_cfg_reg;

    run_entry_t           run_mem [0:RUN_DEPTH];
    logic [OFF_W-1:0]     chunk_mem [0:CHUNK_DEPTH];
    logic [SIZE_W-1:0]    sample_mem [0:SAMPLE_DEPTH];
    run_entry_t           run_q_reg;
    logic [OFF_W-1:0]     chunk_q_reg;
    logic [SIZE_W-1:0]    sample_q_reg;

    logic [OP_W-1:0]      op_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [RUN_AW-1:0]    s_reg;
    logic [COUNT_W-1:0]   count_reg;
    run_entry_t           cur_reg;
    run_entry_t           nxt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [SPC_W-1:0]     rem_reg;
    logic [DIVCNT_W-1:0]  div_cnt_reg;
    logic [COUNT_W-1:0]   idx_reg;
    logic [COUNT_W:0]     end_reg;
    logic [OFF_W-1:0]     acc_reg;
    logic [PROD_W-1:0]    size_reg;
    logic [OFF_W-1:0]     res_off_reg;
    logic [SIZE_W-1:0]    res_size_reg;
    logic [DESC_W-1:0]    res_desc_reg;
    logic [STS_W-1:0]     res_sts_reg;
    logic [OFF_W-1:0]     byte_offset_reg;
    logic [SIZE_W-1:0]    byte_size_reg;
    logic [DESC_W-1:0]    description_index_reg;
    logic [STS_W-1:0]     status_reg;

    logic [RUNS_W-1:0]    runs;
    logic [SAMPLES_W-1:0] samples;
    logic [CHUNKS_W-1:0]  chunks;
    logic                 is_sample;
    logic [FIRST_W-1:0]   run_span;
    logic [FIRST_W+SPC_W-1:0] run_prod;
    logic [PROD_W:0]      walk_sum;
    logic [NUM_W-1:0]     delta;
    logic [SPC_W:0]       trial;
    logic [SPC_W:0]       trial_diff;
    logic                 trial_ge;
    logic [NUM_W:0]       sq_chunk;
    logic [NUM_W-1:0]     chunk_span;
    logic [NUM_W+SPC_W-1:0] cq_prod;
    logic [RUN_AW-1:0]    run_addr;
    logic [CHUNK_AW-1:0]  chunk_addr;
    logic [SAMPLE_AW-1:0] sample_addr;
    logic                 run_we;
    logic                 chunk_we;
    logic                 sample_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_reg       <= '0;
            runs_cfg_reg    <= '0;
            samples_cfg_reg <= '0;
            chunks_cfg_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_FIXED_SIZE:   fixed_reg       <= cfg_data;
                CFG_RUN_COUNT:    runs_cfg_reg    <= cfg_data[RUNS_W-1:0];
                CFG_SAMPLE_COUNT: samples_cfg_reg <= cfg_data[SAMPLES_W-1:0];
                CFG_CHUNK_COUNT:  chunks_cfg_reg  <= cfg_data[CHUNKS_W-1:0];
            endcase
        end
    end

    assign runs    = (runs_cfg_reg > RUNS_W'(RUN_DEPTH)) ? RUNS_W'(RUN_DEPTH) : runs_cfg_reg;
    assign samples = (samples_cfg_reg > SAMPLES_W'(SAMPLE_DEPTH)) ?
                     SAMPLES_W'(SAMPLE_DEPTH) : samples_cfg_reg;
    assign chunks  = (chunks_cfg_reg > CHUNKS_W'(CHUNK_DEPTH)) ?
                     CHUNKS_W'(CHUNK_DEPTH) : chunks_cfg_reg;

    assign is_sample  = (op_reg == OP_SAMPLE_QUERY);
    assign run_span   = (run_q_reg.first > cur_reg.first) ? (run_q_reg.first - cur_reg.first)
                                                          : '0;
    assign run_prod   = run_span * cur_reg.spc;
    assign walk_sum   = (PROD_W+1)'(count_reg) + (PROD_W+1)'(prod_reg);
    assign delta      = num_reg - count_reg[NUM_W-1:0];
    assign trial      = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, cur_reg.spc});
    assign trial_diff = trial - {1'b0, cur_reg.spc};
    assign sq_chunk   = (NUM_W+1)'(cur_reg.first) + (NUM_W+1)'(quo_reg);
    assign chunk_span = num_reg - NUM_W'(cur_reg.first);
    assign cq_prod    = chunk_span * cur_reg.spc;

    always_comb
    begin
        flags.is_query    = is_sample || (op_reg == OP_CHUNK_QUERY);
        flags.is_sample   = is_sample;
        flags.range_bad   = (num_reg == '0) || (runs == '0) ||
                            (is_sample ? (num_reg > NUM_W'(samples))
                                       : (num_reg > NUM_W'(chunks)));
        flags.more_runs   = (RUNS_W'(s_reg) < runs);
        flags.chunk_break = (NUM_W'(run_q_reg.first) > num_reg);
        flags.step_hit    = ((PROD_W+1)'(num_reg) < walk_sum);
        flags.spc_zero    = (cur_reg.spc == '0);
        flags.below_first = (num_reg < NUM_W'(cur_reg.first));
        flags.div_last    = (div_cnt_reg == '0);
        flags.chunk_bad   = (sq_chunk == '0) || (sq_chunk > (NUM_W+1)'(chunks));
        flags.fixed_on    = (fixed_reg != '0);
        flags.sq_more     = (idx_reg < COUNT_W'(num_reg));
        flags.cq_more     = ((COUNT_W+1)'(idx_reg) < end_reg) &&
                            (idx_reg <= COUNT_W'(samples));
    end

    assign run_addr    = (cmd.op == DP_START) ? RUN_AW'(1) : (s_reg + RUN_AW'(1));
    assign chunk_addr  = is_sample ? sq_chunk[CHUNK_AW-1:0] : num_reg[CHUNK_AW-1:0];
    assign sample_addr = idx_reg[SAMPLE_AW-1:0];

    assign run_we    = (cmd.op == DP_LATCH) && (operation == OP_LOAD_RUN) &&
                       (table_index != '0) && (table_index <= IDX_W'(RUN_DEPTH));
    assign chunk_we  = (cmd.op == DP_LATCH) && (operation == OP_LOAD_CHUNK) &&
                       (table_index != '0) && (table_index <= IDX_W'(CHUNK_DEPTH));
    assign sample_we = (cmd.op == DP_LATCH) && (operation == OP_LOAD_SAMPLE) &&
                       (table_index != '0) && (table_index <= IDX_W'(SAMPLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (run_we)
        begin
            run_mem[table_index[RUN_AW-1:0]] <= '{first: run_first_chunk,
                                                   spc:   run_samples_per_chunk,
                                                   desc:  run_description_index};
        end
        run_q_reg <= run_mem[run_addr];
    end

    always_ff @(posedge clk)
    begin
        if (chunk_we)
        begin
            chunk_mem[table_index[CHUNK_AW-1:0]] <= chunk_byte_offset;
        end
        chunk_q_reg <= chunk_mem[chunk_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sample_we)
        begin
            sample_mem[table_index[SAMPLE_AW-1:0]] <= sample_byte_size;
        end
        sample_q_reg <= sample_mem[sample_addr];
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_IDLE:
            begin
            end
            DP_LATCH:
            begin
                op_reg  <= operation;
                num_reg <= query_number;
            end
            DP_START:
            begin
                s_reg     <= RUN_AW'(1);
                count_reg <= COUNT_W'(1);
            end
            DP_CUR_TAKE:
            begin
                cur_reg <= run_q_reg;
            end
            DP_NXT_TAKE:
            begin
                nxt_reg  <= run_q_reg;
                prod_reg <= PROD_W'(run_prod);
            end
            DP_ADVANCE:
            begin
                count_reg <= count_reg + prod_reg[COUNT_W-1:0];
                cur_reg   <= nxt_reg;
                s_reg     <= s_reg + RUN_AW'(1);
            end
            DP_DIV_INIT:
            begin
                quo_reg     <= delta;
                rem_reg     <= '0;
                div_cnt_reg <= DIVCNT_W'(NUM_W - 1);
            end
            DP_DIV_STEP:
            begin
                rem_reg     <= trial_ge ? trial_diff[SPC_W-1:0] : trial[SPC_W-1:0];
                quo_reg     <= {quo_reg[NUM_W-2:0], trial_ge};
                div_cnt_reg <= div_cnt_reg - DIVCNT_W'(1);
            end
            DP_SQ_OFF:
            begin
                idx_reg <= COUNT_W'(num_reg) - COUNT_W'(rem_reg);
            end
            DP_SQ_FIX_MUL:
            begin
                acc_reg  <= chunk_q_reg;
                prod_reg <= rem_reg * fixed_reg;
            end
            DP_SQ_FIX_FIN:
            begin
                res_off_reg  <= acc_reg + OFF_W'(prod_reg);
                res_size_reg <= fixed_reg;
                res_desc_reg <= cur_reg.desc;
                res_sts_reg  <= STS_OK;
            end
            DP_SQ_SUM_INIT:
            begin
                acc_reg <= chunk_q_reg;
            end
            DP_SQ_ACC:
            begin
                acc_reg <= acc_reg + OFF_W'(sample_q_reg);
                idx_reg <= idx_reg + COUNT_W'(1);
            end
            DP_SQ_FIN:
            begin
                res_off_reg  <= acc_reg;
                res_size_reg <= sample_q_reg;
                res_desc_reg <= cur_reg.desc;
                res_sts_reg  <= STS_OK;
            end
            DP_CQ_MUL:
            begin
                prod_reg <= PROD_W'(cq_prod);
            end
            DP_CQ_ADD:
            begin
                count_reg <= count_reg + prod_reg[COUNT_W-1:0];
            end
            DP_CQ_FIX_MUL:
            begin
                acc_reg  <= chunk_q_reg;
                size_reg <= cur_reg.spc * fixed_reg;
            end
            DP_CQ_SUM_INIT:
            begin
                acc_reg  <= chunk_q_reg;
                idx_reg  <= count_reg;
                end_reg  <= (COUNT_W+1)'(count_reg) + (COUNT_W+1)'(cur_reg.spc);
                size_reg <= '0;
            end
            DP_CQ_ACC:
            begin
                size_reg <= size_reg + PROD_W'(sample_q_reg);
                idx_reg  <= idx_reg + COUNT_W'(1);
            end
            DP_CQ_FIN:
            begin
                res_off_reg  <= acc_reg;
                res_size_reg <= (size_reg > SIZE_SAT) ? SIZE_SAT[SIZE_W-1:0]
                                                      : size_reg[SIZE_W-1:0];
                res_desc_reg <= cur_reg.desc;
                res_sts_reg  <= STS_OK;
            end
            DP_ERR_RANGE:
            begin
                res_off_reg  <= '0;
                res_size_reg <= '0;
                res_desc_reg <= '0;
                res_sts_reg  <= STS_RANGE;
            end
            DP_ERR_ZERO:
            begin
                res_off_reg  <= '0;
                res_size_reg <= '0;
                res_desc_reg <= '0;
                res_sts_reg  <= STS_ZERO;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            byte_offset_reg       <= res_off_reg;
            byte_size_reg         <= res_size_reg;
            description_index_reg <= res_desc_reg;
            status_reg            <= res_sts_reg;
        end
    end

    assign byte_offset       = byte_offset_reg;
    assign byte_size         = byte_size_reg;
    assign description_index = description_index_reg;
    assign status            = status_reg;

endmodule

// ----- rtl/sample_table_offset_resolver.sv -----
// Top level of the sample table offset resolver: controller, datapath and checks.
//
// Usage: items enter on in_valid/in_stall, one per beat. Load beats (run entry,
// chunk offset, sample size) write one slot of a table and give no result.
// Query beats give one result beat on out_valid/out_stall. Registers are to
// be written through cfg_write_en/cfg_index/cfg_data only while idle; the user
// is bound to this, and the block itself does not enforce it.
// Sample query: a walk over the runs, 13 divide steps and a sum over the
// earlier samples in the chunk; with a fixed sample size there is no
// per-sample term. Chunk query: a walk over the runs and a sum over the
// samples of the chunk, with no per-sample term for a fixed sample size.
// Errors finish at the check that finds them. in_stall is high while an item
// is at work; a finished result sits in the output register while the next
// item is accepted, and holds under out_stall. Reset clears the configuration
// registers and the control state; table contents are undefined until
// loaded, with no clearing pass.
module sample_table_offset_resolver
    import stor_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic [IDX_W-1:0]      table_index,
    input  logic [FIRST_W-1:0]    run_first_chunk,
    input  logic [SPC_W-1:0]      run_samples_per_chunk,
    input  logic [DESC_W-1:0]     run_description_index,
    input  logic [OFF_W-1:0]      chunk_byte_offset,
    input  logic [SIZE_W-1:0]     sample_byte_size,
    input  logic [NUM_W-1:0]      query_number,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OFF_W-1:0]      byte_offset,
    output logic [SIZE_W-1:0]     byte_size,
    output logic [DESC_W-1:0]     description_index,
    output logic [STS_W-1:0]      status
);

    stor_cmd_t   cmd;
    stor_flags_t flags;

    stor_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .flags     (flags),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    stor_dpath u_dpath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write_en          (cfg_write_en),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .operation             (operation),
        .table_index           (table_index),
        .run_first_chunk       (run_first_chunk),
        .run_samples_per_chunk (run_samples_per_chunk),
        .run_description_index (run_description_index),
        .chunk_byte_offset     (chunk_byte_offset),
        .sample_byte_size      (sample_byte_size),
        .query_number          (query_number),
        .cmd                   (cmd),
        .flags                 (flags),
        .byte_offset           (byte_offset),
        .byte_size             (byte_size),
        .description_index     (description_index),
        .status                (status)
    );

`ifndef SYNTH
    a_err_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STS_OK) |->
        (byte_offset == '0 && byte_size == '0 && description_index == '0))
        else $error("error beat carries nonzero payload");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STS_OK || status == STS_RANGE || status == STS_ZERO))
        else $error("result beat carries an undefined status");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");
`endif

endmodule
